// ----- design/srctl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srctl_pkg
// Shared types and constants for the sonar ranging controller.
// ----------------------------------------------------------------------------
package srctl_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned ScaleW = 8;
  localparam int unsigned ProdW  = CntW + ScaleW;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [CntW-1:0]   TimeoutRst = 16'd100;
  localparam logic [ScaleW-1:0] ScaleRst   = 8'd1;
  localparam logic [CntW-1:0]   CntMax     = '1;

  // register index, taken from the word address bit
  typedef enum logic [0:0] {
    REG_TIMEOUT = 1'b0,
    REG_SCALE   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    SEQ_INIT     = 3'd0,
    SEQ_WAIT_REQ = 3'd1,
    SEQ_SET_TRIG = 3'd2,
    SEQ_CLR_TRIG = 3'd3,
    SEQ_GET_RES  = 3'd4
  } seq_state_e;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? v : v + 1'b1;
  endfunction

endpackage

// ----- design/sonar_ranging_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sonar_ranging_controller_core
// Tick-driven trigger/echo sequencer for an ultrasonic range finder.
// ----------------------------------------------------------------------------
// Each accepted request is one tick: the sequencer and echo detector update
// in the accepting cycle and the tick's result appears in the output register
// on the next cycle. One request per cycle is taken, also while a result
// waits, as long as the output register is empty or is being drained in the
// same cycle; the single output register sets that figure. Write
// timeout_ticks at 0x0 and the distance scale at 0x4 only while idle.
module sonar_ranging_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick requests
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          echo_level_i,
  input  logic                          start_request_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          trigger_level_o,
  output logic [srctl_pkg::CntW-1:0]    distance_o,
  output logic                          measure_done_o,
  output logic                          timed_out_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srctl_pkg::AddrW-1:0]   paddr,
  input  logic [srctl_pkg::DataW-1:0]   pwdata,
  output logic [srctl_pkg::DataW-1:0]   prdata,
  output logic                          pready
);
  import srctl_pkg::*;

  logic [CntW-1:0]   timeout_q;
  logic [ScaleW-1:0] scale_q;

  seq_state_e        state_q, state_d;
  logic [CntW-1:0]   wait_q, wait_d;
  logic              start_pend_q, start_pend_d;
  logic              in_pulse_q, in_pulse_d;
  logic [CntW-1:0]   echo_cnt_q, echo_cnt_d;
  logic [CntW-1:0]   echo_res_q, echo_res_d;
  logic              echo_pend_q, echo_pend_d;
  logic [CntW-1:0]   dist_q, dist_d;
  logic              trig_q, trig_d;
  logic              done_d, tmo_d;

  logic              out_valid_q;
  logic              out_trig_q, out_done_q, out_tmo_q;
  logic [CntW-1:0]   out_dist_q;

  logic              in_fire;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;
  logic [ProdW-1:0]  prod;

  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite & pready;
  assign cfg_idx    = reg_idx_e'(paddr[2]);
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  always_comb begin
    case (cfg_idx)
      REG_TIMEOUT: prdata = DataW'(timeout_q);
      REG_SCALE:   prdata = DataW'(scale_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
      scale_q   <= ScaleRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TIMEOUT: timeout_q <= pwdata[CntW-1:0];
        REG_SCALE:   scale_q   <= pwdata[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  assign prod = ProdW'(scale_q) * ProdW'(echo_res_q);

  // sequencer step, then detector step
  always_comb begin
    state_d      = state_q;
    wait_d       = wait_q;
    start_pend_d = start_pend_q | start_request_i;
    echo_pend_d  = echo_pend_q;
    dist_d       = dist_q;
    trig_d       = trig_q;
    done_d       = 1'b0;
    tmo_d        = 1'b0;
    in_pulse_d   = in_pulse_q;
    echo_cnt_d   = echo_cnt_q;
    echo_res_d   = echo_res_q;

    case (state_q)
      SEQ_INIT: begin
        trig_d  = 1'b0;
        state_d = SEQ_WAIT_REQ;
      end
      SEQ_WAIT_REQ: begin
        if (start_pend_d) begin
          start_pend_d = 1'b0;
          wait_d       = '0;
          state_d      = SEQ_SET_TRIG;
        end
      end
      SEQ_SET_TRIG: begin
        trig_d  = 1'b1;
        state_d = SEQ_CLR_TRIG;
      end
      SEQ_CLR_TRIG: begin
        trig_d  = 1'b0;
        state_d = SEQ_GET_RES;
      end
      SEQ_GET_RES: begin
        wait_d = sat_inc(wait_q);
        if (echo_pend_q) begin
          echo_pend_d = 1'b0;
          dist_d      = (|prod[ProdW-1:CntW]) ? CntMax : prod[CntW-1:0];
          done_d      = 1'b1;
          state_d     = SEQ_WAIT_REQ;
        end else if (wait_d >= timeout_q) begin
          tmo_d   = 1'b1;
          state_d = SEQ_WAIT_REQ;
        end
      end
      default: state_d = SEQ_INIT;
    endcase

    if (echo_level_i) begin
      echo_cnt_d = sat_inc(echo_cnt_q);
      in_pulse_d = 1'b1;
    end else if (in_pulse_q) begin
      // falling edge closes the pulse and posts its length
      echo_res_d  = echo_cnt_q;
      echo_cnt_d  = '0;
      echo_pend_d = 1'b1;
      in_pulse_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SEQ_INIT;
      wait_q       <= '0;
      start_pend_q <= 1'b0;
      in_pulse_q   <= 1'b0;
      echo_cnt_q   <= '0;
      echo_res_q   <= '0;
      echo_pend_q  <= 1'b0;
      dist_q       <= '0;
      trig_q       <= 1'b0;
    end else if (in_fire) begin
      state_q      <= state_d;
      wait_q       <= wait_d;
      start_pend_q <= start_pend_d;
      in_pulse_q   <= in_pulse_d;
      echo_cnt_q   <= echo_cnt_d;
      echo_res_q   <= echo_res_d;
      echo_pend_q  <= echo_pend_d;
      dist_q       <= dist_d;
      trig_q       <= trig_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_trig_q <= trig_d;
      out_dist_q <= dist_d;
      out_done_q <= done_d;
      out_tmo_q  <= tmo_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign trigger_level_o = out_trig_q;
  assign distance_o      = out_dist_q;
  assign measure_done_o  = out_done_q;
  assign timed_out_o     = out_tmo_q;

  // trigger is high only for the tick spent in the pulse state
  a_trig_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_q |-> (state_q == SEQ_CLR_TRIG))
    else $error("trigger high outside pulse state");

  a_done_xor_tmo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_done_q && out_tmo_q))
    else $error("done and timeout in one result");

  a_end_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (done_d || tmo_d)) |=> (state_q == SEQ_WAIT_REQ))
    else $error("measurement end did not return to wait");

  a_cnt_in_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (echo_cnt_q != '0) |-> in_pulse_q)
    else $error("echo count outside a pulse");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sonar ranging controller core. Tick requests
// come from a queue through a valid/ready driver. Each accepted tick runs
// through an in-bench model of the trigger sequencer and echo detector, and
// the monitor compares every result field with the oldest expected one.
// Register settings change between phases over the APB port.
// ----------------------------------------------------------------------------
module tb_top;
  import srctl_pkg::*;

  localparam longint unsigned LimitNs    = 5_000_000;
  localparam int unsigned     HoldCycles = 400;
  localparam int unsigned     LongPulse  = 40;

  typedef struct packed {
    logic echo;
    logic start;
  } tick_req_t;

  typedef struct packed {
    logic            trig;
    logic [CntW-1:0] range_cm;
    logic            done;
    logic            tmo;
  } range_res_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic              echo_level_i    = 1'b0;
  logic              start_request_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic              trigger_level_o;
  logic [CntW-1:0]   distance_o;
  logic              measure_done_o;
  logic              timed_out_o;
  logic              psel            = 1'b0;
  logic              penable         = 1'b0;
  logic              pwrite          = 1'b0;
  logic [AddrW-1:0]  paddr           = '0;
  logic [DataW-1:0]  pwdata          = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  sonar_ranging_controller_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .echo_level_i    (echo_level_i),
    .start_request_i (start_request_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .trigger_level_o (trigger_level_o),
    .distance_o      (distance_o),
    .measure_done_o  (measure_done_o),
    .timed_out_o     (timed_out_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk_i = ~clk_i;

  tick_req_t   pend_ticks[$];
  range_res_t  exp_results[$];
  tick_req_t   drv_tick;
  range_res_t  mon_want;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned err_cnt       = 0;

  // ranging model state
  seq_state_e        seq_q;
  logic [CntW-1:0]   wait_cnt;
  logic [CntW-1:0]   echo_cnt;
  logic [CntW-1:0]   echo_len;
  logic [CntW-1:0]   dist_q;
  logic              start_pend;
  logic              in_pulse;
  logic              echo_pend;
  logic              trig_q;
  logic [CntW-1:0]   cfg_timeout;
  logic [ScaleW-1:0] cfg_scale;

  task automatic ranging_reset();
    cfg_timeout = TimeoutRst;
    cfg_scale   = ScaleRst;
    seq_q       = SEQ_INIT;
    wait_cnt    = '0;
    echo_cnt    = '0;
    echo_len    = '0;
    dist_q      = '0;
    start_pend  = 1'b0;
    in_pulse    = 1'b0;
    echo_pend   = 1'b0;
    trig_q      = 1'b0;
  endtask

  // One tick: sequencer first, then the echo detector.
  function automatic range_res_t range_tick(input logic echo, input logic start);
    range_res_t        r;
    logic [ProdW-1:0]  prod;
    r = '0;
    if (start) start_pend = 1'b1;
    case (seq_q)
      SEQ_INIT: begin
        trig_q = 1'b0;
        seq_q  = SEQ_WAIT_REQ;
      end
      SEQ_WAIT_REQ: begin
        if (start_pend) begin
          start_pend = 1'b0;
          wait_cnt   = '0;
          seq_q      = SEQ_SET_TRIG;
        end
      end
      SEQ_SET_TRIG: begin
        trig_q = 1'b1;
        seq_q  = SEQ_CLR_TRIG;
      end
      SEQ_CLR_TRIG: begin
        trig_q = 1'b0;
        seq_q  = SEQ_GET_RES;
      end
      SEQ_GET_RES: begin
        if (wait_cnt != '1) wait_cnt = wait_cnt + 1'b1;
        if (echo_pend) begin
          echo_pend = 1'b0;
          prod      = cfg_scale * echo_len;
          dist_q    = (prod > ProdW'(16'hFFFF)) ? 16'hFFFF : prod[CntW-1:0];
          r.done    = 1'b1;
          seq_q     = SEQ_WAIT_REQ;
        end else if (wait_cnt >= cfg_timeout) begin
          r.tmo = 1'b1;
          seq_q = SEQ_WAIT_REQ;
        end
      end
      default: seq_q = SEQ_INIT;
    endcase

    if (echo) begin
      if (echo_cnt != '1) echo_cnt = echo_cnt + 1'b1;
      in_pulse = 1'b1;
    end else if (in_pulse) begin
      echo_len  = echo_cnt;
      echo_cnt  = '0;
      echo_pend = 1'b1;
      in_pulse  = 1'b0;
    end

    r.trig     = trig_q;
    r.range_cm = dist_q;
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      echo_level_i    <= 1'b0;
      start_request_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        exp_results.push_back(range_tick(echo_level_i, start_request_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pend_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_tick = pend_ticks.pop_front();
          in_valid_i      <= 1'b1;
          echo_level_i    <= drv_tick.echo;
          start_request_i <= drv_tick.start;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (exp_results.size() == 0) begin
          note_mismatch("result with nothing expected");
        end else begin
          mon_want = exp_results.pop_front();
          if (trigger_level_o !== mon_want.trig)
            note_mismatch($sformatf("trigger_level %b, expected %b",
                                    trigger_level_o, mon_want.trig));
          if (distance_o !== mon_want.range_cm)
            note_mismatch($sformatf("distance %0d, expected %0d",
                                    distance_o, mon_want.range_cm));
          if (measure_done_o !== mon_want.done)
            note_mismatch($sformatf("measure_done %b, expected %b",
                                    measure_done_o, mon_want.done));
          if (timed_out_o !== mon_want.tmo)
            note_mismatch($sformatf("timed_out %b, expected %b",
                                    timed_out_o, mon_want.tmo));
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic push_tick(input logic echo, input logic start);
    tick_req_t t;
    t.echo  = echo;
    t.start = start;
    pend_ticks.push_back(t);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [DataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TIMEOUT: cfg_timeout = val[CntW-1:0];
      REG_SCALE:   cfg_scale   = val[ScaleW-1:0];
      default: ;
    endcase
  endtask

  task automatic reg_check(input reg_idx_e idx, input logic [DataW-1:0] want);
    logic [DataW-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      note_mismatch($sformatf("register %s reads %0h, expected %0h", idx.name(), got, want));
  endtask

  task automatic write_regs(input logic [CntW-1:0] tmo, input logic [ScaleW-1:0] scl);
    reg_write(REG_TIMEOUT, DataW'(tmo));
    reg_write(REG_SCALE, DataW'(scl));
    reg_check(REG_TIMEOUT, DataW'(tmo));
    reg_check(REG_SCALE, DataW'(scl));
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pend_ticks.size() != 0 || in_valid_i || exp_results.size() != 0);
  endtask

  // Mostly start/echo-pulse measurements with random timing, some noise.
  task automatic fill_random(input int unsigned n_items);
    int unsigned added, lead, hi_len, tail;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(9) < 3) begin
        lead = $urandom_range(1, 8);
        repeat (lead) push_tick(1'($urandom_range(1)), $urandom_range(3) == 0);
        added += lead;
      end else begin
        lead   = $urandom_range(0, 4);
        tail   = $urandom_range(1, 6);
        if ($urandom_range(5) == 0) hi_len = 0;
        else if ($urandom_range(24) == 0) hi_len = $urandom_range(250, 300);
        else hi_len = $urandom_range(1, 12);
        push_tick(1'b0, 1'b1);
        repeat (lead) push_tick(1'b0, $urandom_range(19) == 0);
        repeat (hi_len) push_tick(1'b1, $urandom_range(19) == 0);
        repeat (tail) push_tick(1'b0, 1'b0);
        added += 1 + lead + hi_len + tail;
      end
    end
  endtask

  task automatic run_phase(input logic [CntW-1:0] tmo, input logic [ScaleW-1:0] scl,
                           input int unsigned n_items);
    write_regs(tmo, scl);
    @(negedge clk_i);
    fill_random(n_items);
    wait_drained();
  endtask

  initial begin
    ranging_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 29;
    recv_idle_pct = 48;
    @(negedge clk_i);

    // directed: reset settings
    push_tick(1'b0, 1'b1);   // start during init tick stays pending
    push_tick(1'b0, 1'b1);   // repeated start, single event
    push_tick(1'b1, 1'b0);   // echo rises during trigger pulse
    push_tick(1'b1, 1'b1);   // start while busy
    push_tick(1'b0, 1'b0);   // echo falls on first wait tick, seen next tick
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b0);   // pending start taken
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);   // stale echo with nothing waiting
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b1);   // start and echo together
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b0);   // stale echo taken here
    push_tick(1'b0, 1'b0);
    wait_drained();

    run_phase(16'd400, 8'd255, 270);
    run_phase(16'd0, 8'd0, 270);
    run_phase(16'd1, 8'd37, 270);
    send_idle_pct = 48;
    recv_idle_pct = 29;
    run_phase(16'd20, 8'd200, 270);
    run_phase(16'd65535, 8'd1, 270);
    run_phase(CntW'($urandom_range(2, 60)), ScaleW'($urandom_range(255)), 270);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // receiver stalls for a long stretch while requests keep coming
    write_regs(16'd50, 8'd128);
    @(negedge clk_i);
    hold_left = HoldCycles;
    fill_random(200);
    repeat (60) push_tick(1'b0, 1'b0);
    wait_drained();

    // largest timeout, start while busy, then a long echo pulse
    write_regs(16'd65535, 8'd2);
    @(negedge clk_i);
    push_tick(1'b0, 1'b1);
    repeat (4) push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    repeat (LongPulse) push_tick(1'b1, 1'b0);
    repeat (3) push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    repeat (8) push_tick(1'b0, 1'b0);
    wait_drained();

    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(LimitNs);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
